FILE: hdl/s4rf_pkg.sv
package s4rf_pkg;

  localparam int RULE_COUNT = 8;
  localparam int SLOT_W     = 3;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 3;

  localparam logic       KIND_REQUEST  = 1'b0;
  localparam logic       KIND_RULE     = 1'b1;

  localparam logic [7:0] SOCKS_VERSION = 8'd4;
  localparam logic [7:0] REPLY_VERSION = 8'd0;
  localparam logic [7:0] CMD_CONNECT   = 8'd1;
  localparam logic [7:0] CMD_BIND      = 8'd2;

  localparam logic [6:0] CODE_GRANT    = 7'd90;
  localparam logic [6:0] CODE_REJECT   = 7'd91;

  localparam logic [1:0] SCOPE_CONNECT = 2'd0;
  localparam logic [1:0] SCOPE_BIND    = 2'd1;
  localparam logic [1:0] SCOPE_BOTH    = 2'd2;
  // spare encoding, covers both commands
  localparam logic [1:0] SCOPE_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    CLS_CONNECT = 2'd0,
    CLS_BIND    = 2'd1,
    CLS_UNKNOWN = 2'd2
  } cls_t;

  typedef struct packed {
    logic        permit;
    logic [1:0]  scope;
    logic [31:0] addr;
    logic [3:0]  wild;
  } rule_t;

  typedef struct packed {
    logic connect;
    logic bind_ok;
  } hit_t;

  // first member sits in the top bits
  typedef struct packed {
    logic [5:0]        pad;
    logic [31:0]       check_addr;
    logic [31:0]       req_addr;
    logic [15:0]       req_port;
    logic [7:0]        req_command;
    logic [7:0]        req_version;
    logic [3:0]        rule_wild;
    logic [31:0]       rule_addr;
    logic [1:0]        rule_scope;
    logic              rule_permit;
    logic [SLOT_W-1:0] rule_slot;
  } in_data_t;

  typedef struct packed {
    logic        pad;
    logic [31:0] reply_addr;
    logic [15:0] reply_port;
    logic [6:0]  reply_code;
    logic [7:0]  reply_version;
  } out_data_t;

  typedef struct packed {
    cls_t command_class;
    logic is_socks4a;
  } out_user_t;

endpackage

FILE: hdl/s4rf_rule_table.sv
module s4rf_rule_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [s4rf_pkg::SLOT_W-1:0]   wr_slot,
  input  s4rf_pkg::rule_t               wr_rule,
  input  logic [31:0]                   check_addr,
  output s4rf_pkg::hit_t                hit
);
  import s4rf_pkg::*;

  rule_t                 rule_r   [RULE_COUNT];
  rule_t                 rule_nxt [RULE_COUNT];
  logic [RULE_COUNT-1:0] hit_connect;
  logic [RULE_COUNT-1:0] hit_bind;

  always_comb begin
    for (int i = 0; i < RULE_COUNT; i++) begin
      rule_nxt[i] = rule_r[i];
      if (wr_en && (32'(wr_slot) == i)) begin
        rule_nxt[i] = wr_rule;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RULE_COUNT; i++) begin
      if (!rst_n) begin
        rule_r[i] <= '0;
      end else begin
        rule_r[i] <= rule_nxt[i];
      end
    end
  end

  // every rule compared in parallel, octets with the wildcard bit set are skipped
  always_comb begin
    for (int i = 0; i < RULE_COUNT; i++) begin
      logic addr_ok;
      addr_ok = 1'b1;
      for (int k = 0; k < 4; k++) begin
        if (!rule_r[i].wild[k] && (rule_r[i].addr[8*k +: 8] != check_addr[8*k +: 8])) begin
          addr_ok = 1'b0;
        end
      end
      hit_connect[i] = rule_r[i].permit && addr_ok && (rule_r[i].scope != SCOPE_BIND);
      hit_bind[i]    = rule_r[i].permit && addr_ok && (rule_r[i].scope != SCOPE_CONNECT);
    end
  end

  assign hit.connect = |hit_connect;
  assign hit.bind_ok = |hit_bind;

endmodule

FILE: hdl/socks4_request_filter.sv
// a request passes through the input stage and then the output register to the result port
// throughput: one transaction per cycle, rule writes and requests alike, while the result
//   port does not stall; all eight rules are compared in parallel in the single compute stage
// rule writes give no result and land in the table as they leave the input stage
// reset (rst_n low, synchronous) empties both stages and clears every rule to not permit
module socks4_request_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // rule_slot, rule_permit, rule_scope, rule_addr, rule_wild, req_version,
  // req_command, req_port, req_addr, check_addr, zero fill
  input  logic [s4rf_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // reply_version, reply_code, reply_port, reply_addr, zero fill
  output logic [s4rf_pkg::OUT_DATA_W-1:0]    out_tdata,
  // is_socks4a, command_class
  output logic [s4rf_pkg::OUT_USER_W-1:0]    out_tuser
);
  import s4rf_pkg::*;

  logic      s1_valid_r;
  logic      s1_kind_r;
  in_data_t  s1_data_r;
  logic      out_valid_r;
  out_data_t out_data_r;
  out_user_t out_user_r;

  logic      s1_adv;
  logic      out_free;
  logic      rule_wr;
  rule_t     wr_rule;
  hit_t      hit;
  cls_t      cls;
  logic      granted;
  out_data_t out_data_nxt;
  out_user_t out_user_nxt;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && ((s1_kind_r == KIND_RULE) || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign rule_wr   = s1_valid_r && (s1_kind_r == KIND_RULE);

  assign wr_rule.permit = s1_data_r.rule_permit;
  assign wr_rule.scope  = s1_data_r.rule_scope;
  assign wr_rule.addr   = s1_data_r.rule_addr;
  assign wr_rule.wild   = s1_data_r.rule_wild;

  s4rf_rule_table u_rule_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (rule_wr),
    .wr_slot    (s1_data_r.rule_slot),
    .wr_rule    (wr_rule),
    .check_addr (s1_data_r.check_addr),
    .hit        (hit)
  );

  always_comb begin
    priority if (s1_data_r.req_command == CMD_CONNECT) begin
      cls = CLS_CONNECT;
    end else if (s1_data_r.req_command == CMD_BIND) begin
      cls = CLS_BIND;
    end else begin
      cls = CLS_UNKNOWN;
    end

    granted = 1'b0;
    if (s1_data_r.req_version == SOCKS_VERSION) begin
      unique case (cls)
        CLS_CONNECT: granted = hit.connect;
        CLS_BIND:    granted = hit.bind_ok;
        default:     granted = 1'b0;
      endcase
    end

    out_data_nxt.pad           = 1'b0;
    out_data_nxt.reply_addr    = s1_data_r.req_addr;
    out_data_nxt.reply_port    = s1_data_r.req_port;
    out_data_nxt.reply_code    = granted ? CODE_GRANT : CODE_REJECT;
    out_data_nxt.reply_version = REPLY_VERSION;

    out_user_nxt.command_class = cls;
    // socks4a marker: 0.0.0.x with x nonzero
    out_user_nxt.is_socks4a    = (s1_data_r.req_addr[31:8] == 24'd0) &&
                                 (s1_data_r.req_addr[7:0] != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv && (s1_kind_r == KIND_REQUEST)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r <= in_tuser;
      s1_data_r <= in_data_t'(in_tdata);
    end
    if (s1_adv && (s1_kind_r == KIND_REQUEST)) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_data_r);
  assign out_tuser  = OUT_USER_W'(out_user_r);

endmodule
